// ===== design/foc_phase_voltage_modulator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the phase voltage modulator
// Shared concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FOC_PHASE_VOLTAGE_MODULATOR_ASSERT_SVH
`define FOC_PHASE_VOLTAGE_MODULATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FOC_PVM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A condition that implies another one in the same cycle.
`define FOC_PVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/foc_pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Phase voltage modulator package
// Register indexes, fixed-point constants, pipeline latencies and the
// sine table generator shared by the modulator modules.
// ----------------------------------------------------------------------------
package foc_pvm_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_POLE_COUNT  = 2'd0,
    REG_DIRECTION   = 2'd1,
    REG_ELEC_OFFSET = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PPC_W       = 7;
  localparam int unsigned OFFSET_W    = 16;

  // Fixed-point constants.
  localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
  localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
  localparam logic signed [16:0] OUT_MAX        = 17'sh0FFFF;
  localparam logic signed [16:0] OUT_MIN        = 17'sh10000;

  // Stage counts of each pipeline section.
  localparam int unsigned ANGLE_LAT  = 2;
  localparam int unsigned SINCOS_LAT = 2;
  localparam int unsigned PARK_LAT   = 3;
  localparam int unsigned CLARKE_LAT = 3;
  localparam int unsigned TOTAL_LAT  = ANGLE_LAT + SINCOS_LAT + PARK_LAT + CLARKE_LAT;

  // Quarter-wave sine entry k for a table of 2^tb steps, Q15, built from a
  // Q30 Taylor series. Evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tb);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic [63:0]        e;
    logic signed [63:0] sum;
    int                 n;
    x    = (HALF_PI_Q30 * 64'(k)) >> tb;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      prod = (term * x) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        8:       term = prod / 64'd272;
        9:       term = prod / 64'd342;
        10:      term = prod / 64'd420;
        11:      term = prod / 64'd506;
        12:      term = prod / 64'd600;
        default: term = prod;
      endcase
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (unsigned'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (e > 64'd32768) begin
      e = 64'd32768;
    end
    return e[15:0];
  endfunction

  // Clamp a rounded phase value to the 17-bit output range.
  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    logic signed [16:0] r;
    if (v > 19'sd65535) begin
      r = OUT_MAX;
    end else if (v < -19'sd65536) begin
      r = OUT_MIN;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ===== design/foc_phase_voltage_modulator.sv =====
// ----------------------------------------------------------------------------
// Phase voltage modulator
// Electrical angle from shaft angle, pole pairs, direction and offset, then
// inverse Park and inverse Clarke into three saturated phase voltages.
//
//   Channel  Ports                                 Handshake
//   request  start_i, shaft_angle_i, uq_i, ud_i    start_i && !busy_o
//   result   out_strobe_o, phase_*_o, elec. angle  one-cycle strobe
//   config   cfg_valid_i/ready_o, index, data      valid && ready
//
// A request is taken every cycle; busy_o stays low.
// Each result passes through two angle stages, two table lookup stages,
// three Park stages and three Clarke stages.
// Reset clears only the valid bits and the configuration registers.
// Results cannot be stalled, so the pipeline never stops.
// ----------------------------------------------------------------------------
`include "foc_phase_voltage_modulator_assert.svh"

module foc_phase_voltage_modulator #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [15:0]                          shaft_angle_i,
  input  logic signed [15:0]                   uq_i,
  input  logic signed [15:0]                   ud_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [foc_pvm_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [foc_pvm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                 out_strobe_o,
  output logic signed [16:0]                   phase_a_o,
  output logic signed [16:0]                   phase_b_o,
  output logic signed [16:0]                   phase_c_o,
  output logic [15:0]                          electrical_angle_o
);

  localparam int unsigned ANG_DLY =
      foc_pvm_pkg::SINCOS_LAT + foc_pvm_pkg::PARK_LAT + foc_pvm_pkg::CLARKE_LAT;

  logic [foc_pvm_pkg::PPC_W-1:0]    pole_pair_q;
  logic                             forward_q;
  logic [foc_pvm_pkg::OFFSET_W-1:0] elec_offset_q;

  logic                                       a_valid_q, b_valid_q;
  logic [ANGLE_BITS-1:0]                      shaft_ext, offset_ext;
  logic [ANGLE_BITS+foc_pvm_pkg::PPC_W-1:0]   prod_full;
  logic [ANGLE_BITS-1:0]                      raw_a_q;
  logic [ANGLE_BITS-1:0]                      ang_b_d, ang_b_q;
  logic signed [15:0]                         uq_a_q, ud_a_q, uq_b_q, ud_b_q;
  logic signed [15:0]                         uq_dly_q [foc_pvm_pkg::SINCOS_LAT];
  logic signed [15:0]                         ud_dly_q [foc_pvm_pkg::SINCOS_LAT];
  logic [ANGLE_BITS-1:0]                      ang_dly_q [ANG_DLY];

  logic               sc_valid;
  logic signed [16:0] sin_val, cos_val;
  logic               pk_valid;
  logic signed [17:0] ualpha, ubeta;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pair_q   <= foc_pvm_pkg::PPC_W'(1);
      forward_q     <= 1'b1;
      elec_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (foc_pvm_pkg::cfg_reg_e'(cfg_index_i))
        foc_pvm_pkg::REG_POLE_COUNT:  pole_pair_q   <= cfg_data_i[foc_pvm_pkg::PPC_W-1:0];
        foc_pvm_pkg::REG_DIRECTION:   forward_q     <= cfg_data_i[0];
        foc_pvm_pkg::REG_ELEC_OFFSET: elec_offset_q <= cfg_data_i[foc_pvm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Angle stage one: pole pairs times shaft angle, wrapped to one turn.
  assign shaft_ext  = ANGLE_BITS'(shaft_angle_i);
  assign offset_ext = ANGLE_BITS'(elec_offset_q);
  assign prod_full  = pole_pair_q * shaft_ext;

  // Angle stage two: direction and zero offset.
  assign ang_b_d = forward_q ? (raw_a_q + offset_ext) : (offset_ext - raw_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_a_q <= prod_full[ANGLE_BITS-1:0];
    uq_a_q  <= uq_i;
    ud_a_q  <= ud_i;
    ang_b_q <= ang_b_d;
    uq_b_q  <= uq_a_q;
    ud_b_q  <= ud_a_q;
  end

  // Voltage commands wait out the table lookup; the angle waits for the result.
  always_ff @(posedge clk_i) begin
    uq_dly_q[0]  <= uq_b_q;
    ud_dly_q[0]  <= ud_b_q;
    ang_dly_q[0] <= ang_b_q;
    for (int i = 1; i < foc_pvm_pkg::SINCOS_LAT; i++) begin
      uq_dly_q[i] <= uq_dly_q[i-1];
      ud_dly_q[i] <= ud_dly_q[i-1];
    end
    for (int j = 1; j < ANG_DLY; j++) begin
      ang_dly_q[j] <= ang_dly_q[j-1];
    end
  end

  foc_pvm_sincos #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .angle_i (ang_b_q),
    .valid_o (sc_valid),
    .sin_o   (sin_val),
    .cos_o   (cos_val)
  );

  foc_pvm_park u_park (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sc_valid),
    .uq_i     (uq_dly_q[foc_pvm_pkg::SINCOS_LAT-1]),
    .ud_i     (ud_dly_q[foc_pvm_pkg::SINCOS_LAT-1]),
    .sin_i    (sin_val),
    .cos_i    (cos_val),
    .valid_o  (pk_valid),
    .ualpha_o (ualpha),
    .ubeta_o  (ubeta)
  );

  foc_pvm_clarke u_clarke (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (pk_valid),
    .ualpha_i  (ualpha),
    .ubeta_i   (ubeta),
    .valid_o   (out_strobe_o),
    .phase_a_o (phase_a_o),
    .phase_b_o (phase_b_o),
    .phase_c_o (phase_c_o)
  );

  assign electrical_angle_o = 16'(ang_dly_q[ANG_DLY-1]);

  // Every result strobe traces back to a request that went through all the pipeline stages.
  `FOC_PVM_ASSERT_IMP(a_result_has_request, out_strobe_o, $past(start_i, foc_pvm_pkg::TOTAL_LAT), "result without a request")
  // The lookup section delivers items in step with its input.
  `FOC_PVM_ASSERT_IMP(a_sincos_in_step, sc_valid, $past(b_valid_q, foc_pvm_pkg::SINCOS_LAT), "lookup valid out of step")

endmodule

// ===== design/foc_pvm_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// Two-stage quarter-wave table lookup: quadrant folding, then table read
// with sign restore. Cosine uses the same fraction one quadrant ahead.
// ----------------------------------------------------------------------------
`include "foc_phase_voltage_modulator_assert.svh"

module foc_pvm_sincos #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [ANGLE_BITS-1:0]     angle_i,
  output logic                      valid_o,
  output logic signed [16:0]        sin_o,
  output logic signed [16:0]        cos_o
);

  localparam int unsigned TABLE_Q = 1 << SINE_TABLE_BITS;
  localparam logic [SINE_TABLE_BITS:0] TABLE_TOP = TABLE_Q[SINE_TABLE_BITS:0];

  // Constant quarter-wave table, entries 0 through a full quarter turn.
  logic [15:0] sine_rom [TABLE_Q+1];

  for (genvar k = 0; k <= TABLE_Q; k++) begin : g_rom
    localparam logic [15:0] ENTRY = foc_pvm_pkg::sine_entry(k, SINE_TABLE_BITS);
    assign sine_rom[k] = ENTRY;
  end

  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [ANGLE_BITS-3:0]      frac;
  logic [SINE_TABLE_BITS-1:0] base_idx;
  logic [SINE_TABLE_BITS:0]   idx_s_d, idx_s_q;
  logic [SINE_TABLE_BITS:0]   idx_c_d, idx_c_q;
  logic                       neg_s_q, neg_c_q;
  logic                       s1_valid_q;
  logic signed [16:0]         sin_d, sin_q;
  logic signed [16:0]         cos_d, cos_q;
  logic                       valid_q;

  assign quad_s = angle_i[ANGLE_BITS-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign frac   = angle_i[ANGLE_BITS-3:0];

  // Truncate the fraction to the table index, or pad it when the table is finer.
  if (ANGLE_BITS - 2 >= SINE_TABLE_BITS) begin : g_trunc
    assign base_idx = frac[ANGLE_BITS-3 -: SINE_TABLE_BITS];
  end else begin : g_pad
    assign base_idx = {frac, {(SINE_TABLE_BITS - ANGLE_BITS + 2){1'b0}}};
  end

  // Odd quadrants run the table backwards.
  always_comb begin
    idx_s_d = quad_s[0] ? (TABLE_TOP - {1'b0, base_idx}) : {1'b0, base_idx};
    idx_c_d = quad_c[0] ? (TABLE_TOP - {1'b0, base_idx}) : {1'b0, base_idx};
  end

  // Stage one: folded indexes and signs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_s_q <= idx_s_d;
    idx_c_q <= idx_c_d;
    neg_s_q <= quad_s[1];
    neg_c_q <= quad_c[1];
  end

  // Stage two: table read and sign restore.
  always_comb begin
    sin_d = $signed({1'b0, sine_rom[idx_s_q]});
    cos_d = $signed({1'b0, sine_rom[idx_c_q]});
    if (neg_s_q) begin
      sin_d = -sin_d;
    end
    if (neg_c_q) begin
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign valid_o = valid_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

  // Sine and cosine stay within one unit and never vanish together.
  `FOC_PVM_ASSERT_IMP(a_sincos_range, valid_q, sin_q <= 17'sd32768 && sin_q >= -17'sd32768 && cos_q <= 17'sd32768 && cos_q >= -17'sd32768, "sine or cosine out of range")
  `FOC_PVM_ASSERT_IMP(a_sincos_nonzero, valid_q, sin_q != 17'sd0 || cos_q != 17'sd0, "sine and cosine both zero")

endmodule

// ===== design/foc_pvm_park.sv =====
// ----------------------------------------------------------------------------
// Inverse Park transform
// Rotates the d and q commands into alpha and beta: products, sums, and a
// round-half-away-from-zero shift, one register stage each.
// ----------------------------------------------------------------------------
module foc_pvm_park (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] uq_i,
  input  logic signed [15:0] ud_i,
  input  logic signed [16:0] sin_i,
  input  logic signed [16:0] cos_i,
  output logic               valid_o,
  output logic signed [17:0] ualpha_o,
  output logic signed [17:0] ubeta_o
);

  logic               v1_q, v2_q, v3_q;
  logic signed [32:0] p_dc_q, p_qs_q, p_qc_q, p_ds_q;
  logic signed [33:0] alpha_sum_q, beta_sum_q;
  logic signed [33:0] alpha_bias, beta_bias;
  logic signed [17:0] ualpha_q, ubeta_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Bias toward the half-away-from-zero point before the arithmetic shift.
  always_comb begin
    alpha_bias = alpha_sum_q[33] ? (alpha_sum_q + 34'sd16383) : (alpha_sum_q + 34'sd16384);
    beta_bias  = beta_sum_q[33] ? (beta_sum_q + 34'sd16383) : (beta_sum_q + 34'sd16384);
  end

  // Stage one: four products; stage two: sums; stage three: rounding.
  always_ff @(posedge clk_i) begin
    p_dc_q      <= ud_i * cos_i;
    p_qs_q      <= uq_i * sin_i;
    p_qc_q      <= uq_i * cos_i;
    p_ds_q      <= ud_i * sin_i;
    alpha_sum_q <= 34'(p_dc_q) - 34'(p_qs_q);
    beta_sum_q  <= 34'(p_qc_q) + 34'(p_ds_q);
    ualpha_q    <= 18'(alpha_bias >>> 15);
    ubeta_q     <= 18'(beta_bias >>> 15);
  end

  assign valid_o  = v3_q;
  assign ualpha_o = ualpha_q;
  assign ubeta_o  = ubeta_q;

endmodule

// ===== design/foc_pvm_clarke.sv =====
// ----------------------------------------------------------------------------
// Inverse Clarke transform
// Splits alpha and beta into three saturated phase voltages: a constant
// multiply, the phase sums, then rounding and saturation.
// ----------------------------------------------------------------------------
`include "foc_phase_voltage_modulator_assert.svh"

module foc_pvm_clarke (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [17:0] ualpha_i,
  input  logic signed [17:0] ubeta_i,
  output logic               valid_o,
  output logic signed [16:0] phase_a_o,
  output logic signed [16:0] phase_b_o,
  output logic signed [16:0] phase_c_o
);

  logic               v1_q, v2_q, v3_q;
  logic signed [34:0] beta_scaled_q;
  logic signed [17:0] ua1_q, ua2_q;
  logic signed [34:0] alpha_half;
  logic signed [34:0] pb_sum_q, pc_sum_q;
  logic signed [34:0] pb_bias, pc_bias;
  logic signed [16:0] phase_a_q, phase_b_q, phase_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Alpha times one half in the Q16 scale of the beta product.
  assign alpha_half = 35'(ua1_q) <<< 15;

  // Round half away from zero ahead of the 16-bit shift.
  always_comb begin
    pb_bias = pb_sum_q[34] ? (pb_sum_q + 35'sd32767) : (pb_sum_q + 35'sd32768);
    pc_bias = pc_sum_q[34] ? (pc_sum_q + 35'sd32767) : (pc_sum_q + 35'sd32768);
  end

  // Stage one: beta times sqrt(3)/2; stage two: phase sums; stage three: output.
  always_ff @(posedge clk_i) begin
    beta_scaled_q <= ubeta_i * foc_pvm_pkg::SQRT3_HALF_Q16;
    ua1_q         <= ualpha_i;
    pb_sum_q      <= beta_scaled_q - alpha_half;
    pc_sum_q      <= -alpha_half - beta_scaled_q;
    ua2_q         <= ua1_q;
    phase_a_q     <= foc_pvm_pkg::sat17(19'(ua2_q));
    phase_b_q     <= foc_pvm_pkg::sat17(19'(pb_bias >>> 16));
    phase_c_q     <= foc_pvm_pkg::sat17(19'(pc_bias >>> 16));
  end

  assign valid_o   = v3_q;
  assign phase_a_o = phase_a_q;
  assign phase_b_o = phase_b_q;
  assign phase_c_o = phase_c_q;

  // Unsaturated phases sum to zero within the rounding of two phases.
  `FOC_PVM_ASSERT_IMP(a_phase_sum, v3_q && phase_a_q != foc_pvm_pkg::OUT_MAX && phase_a_q != foc_pvm_pkg::OUT_MIN && phase_b_q != foc_pvm_pkg::OUT_MAX && phase_b_q != foc_pvm_pkg::OUT_MIN && phase_c_q != foc_pvm_pkg::OUT_MAX && phase_c_q != foc_pvm_pkg::OUT_MIN, (19'(phase_a_q) + 19'(phase_b_q) + 19'(phase_c_q)) <= 19'sd1 && (19'(phase_a_q) + 19'(phase_b_q) + 19'(phase_c_q)) >= -19'sd1, "phase voltages do not balance")

endmodule

// ===== bench/foc_pvm_checker.sv =====
// ----------------------------------------------------------------------------
// Phase voltage modulator checker
// Watches the request, configuration and result channels of the modulator.
// It predicts the phase voltages and electrical angle of every accepted
// request and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module foc_pvm_checker #(
  parameter int unsigned ANGLE_W = 16,
  parameter int unsigned TABLE_W = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [15:0]                         shaft_angle_i,
  input  logic signed [15:0]                  uq_i,
  input  logic signed [15:0]                  ud_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [foc_pvm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [foc_pvm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                out_strobe_i,
  input  logic signed [16:0]                  phase_a_i,
  input  logic signed [16:0]                  phase_b_i,
  input  logic signed [16:0]                  phase_c_i,
  input  logic [15:0]                         electrical_angle_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  typedef struct packed {
    logic signed [16:0] phase_a;
    logic signed [16:0] phase_b;
    logic signed [16:0] phase_c;
    logic [15:0]        angle;
  } phase_result_t;

  localparam int unsigned TABLE_N      = 1 << TABLE_W;
  localparam int          INDEX_DROP   = int'(ANGLE_W) - 2 - int'(TABLE_W);
  localparam bit [63:0]   ANGLE_MASK   = (64'd1 << ANGLE_W) - 64'd1;
  localparam bit [63:0]   QUARTER_TURN = 64'd1 << (ANGLE_W - 2);
  localparam bit [63:0]   PI_HALF_Q30  = 64'd1686629713;
  localparam longint      ROOT3_HALF   = 56756;

  int            sine_quarter [0:TABLE_N];
  logic [6:0]    pair_count;
  logic          forward;
  logic [15:0]   angle_offset;
  phase_result_t expected_phases [$];
  int unsigned   mismatch_count;

  // Quarter-wave sine table in Q15 from a Q30 Taylor series.
  initial begin
    bit [63:0] x;
    bit [63:0] term;
    longint    sum;
    bit [63:0] entry;
    for (int k = 0; k <= int'(TABLE_N); k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_W;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      entry = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (entry > 64'd32768) begin
        entry = 64'd32768;
      end
      sine_quarter[k] = int'(entry);
    end
  end

  // Sine of a wrapped angle: quadrant mirror and sign around the table.
  function automatic int sine_at(bit [63:0] ang);
    bit [1:0]    quad;
    bit [63:0]   frac;
    int unsigned idx;
    int          v;
    quad = 2'((ang >> (ANGLE_W - 2)) & 64'd3);
    frac = ang & (QUARTER_TURN - 64'd1);
    if (INDEX_DROP >= 0) begin
      idx = 32'(frac >> INDEX_DROP);
    end else begin
      idx = 32'(frac << (-INDEX_DROP));
    end
    idx = idx & (TABLE_N - 1);
    if (quad[0]) begin
      idx = TABLE_N - idx;
    end
    v = sine_quarter[idx];
    return quad[1] ? -v : v;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic longint round_half_away(longint x, int unsigned n);
    longint half;
    half = longint'(1) << (n - 1);
    if (x >= 0) begin
      return (x + half) >>> n;
    end
    return -((-x + half) >>> n);
  endfunction

  function automatic logic signed [16:0] clamp17(longint v);
    if (v > 65535) begin
      v = 65535;
    end
    if (v < -65536) begin
      v = -65536;
    end
    return 17'(v);
  endfunction

  // Electrical angle, inverse Park and inverse Clarke for one request.
  function automatic phase_result_t predict_phases(logic [15:0] shaft,
                                                   logic signed [15:0] uq,
                                                   logic signed [15:0] ud);
    bit [63:0]     raw;
    bit [63:0]     ang;
    longint        s;
    longint        c;
    longint        alpha;
    longint        beta;
    phase_result_t r;
    raw = 64'(pair_count) * (64'(shaft) & ANGLE_MASK);
    if (!forward) begin
      raw = 64'd0 - raw;
    end
    ang   = (raw + (64'(angle_offset) & ANGLE_MASK)) & ANGLE_MASK;
    s     = sine_at(ang);
    c     = sine_at((ang + QUARTER_TURN) & ANGLE_MASK);
    alpha = round_half_away(longint'(ud) * c - longint'(uq) * s, 15);
    beta  = round_half_away(longint'(uq) * c + longint'(ud) * s, 15);
    r.phase_a = clamp17(alpha);
    r.phase_b = clamp17(round_half_away(ROOT3_HALF * beta - 32768 * alpha, 16));
    r.phase_c = clamp17(round_half_away(-32768 * alpha - ROOT3_HALF * beta, 16));
    r.angle   = ang[15:0];
    return r;
  endfunction

  // Compare results, then record new requests and register writes.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    phase_result_t want;
    if (!rst_ni) begin
      expected_phases.delete();
      pair_count     = 7'd1;
      forward        = 1'b1;
      angle_offset   = 16'd0;
      mismatch_count = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      if (out_strobe_i) begin
        if (expected_phases.size() == 0) begin
          $error("result with no request waiting: phase_a %0d angle %0d",
                 phase_a_i, electrical_angle_i);
          mismatch_count++;
        end else begin
          want = expected_phases.pop_front();
          if (phase_a_i !== want.phase_a) begin
            $error("phase_a: expected %0d, got %0d", want.phase_a, phase_a_i);
            mismatch_count++;
          end
          if (phase_b_i !== want.phase_b) begin
            $error("phase_b: expected %0d, got %0d", want.phase_b, phase_b_i);
            mismatch_count++;
          end
          if (phase_c_i !== want.phase_c) begin
            $error("phase_c: expected %0d, got %0d", want.phase_c, phase_c_i);
            mismatch_count++;
          end
          if (electrical_angle_i !== want.angle) begin
            $error("electrical_angle: expected %0d, got %0d", want.angle,
                   electrical_angle_i);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_phases.push_back(predict_phases(shaft_angle_i, uq_i, ud_i));
      end
      // Writes to an unused index are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          foc_pvm_pkg::REG_POLE_COUNT:  pair_count   = cfg_data_i[6:0];
          foc_pvm_pkg::REG_DIRECTION:   forward      = cfg_data_i[0];
          foc_pvm_pkg::REG_ELEC_OFFSET: angle_offset = cfg_data_i[15:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatch_count;
      pending_o    <= $unsigned(expected_phases.size());
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Phase voltage modulator testbench
// Drives directed and random requests through the modulator under a range
// of pole pair, direction and offset settings, with bursty request timing.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned TABLE_W     = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [foc_pvm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                                clk_i;
  logic                                rst_ni        = 1'b0;
  logic                                start_i       = 1'b0;
  logic                                busy_o;
  logic [15:0]                         shaft_angle_i = '0;
  logic signed [15:0]                  uq_i          = '0;
  logic signed [15:0]                  ud_i          = '0;
  logic                                cfg_valid_i   = 1'b0;
  logic                                cfg_ready_o;
  logic [foc_pvm_pkg::CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [foc_pvm_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                                out_strobe_o;
  logic signed [16:0]                  phase_a_o;
  logic signed [16:0]                  phase_b_o;
  logic signed [16:0]                  phase_c_o;
  logic [15:0]                         electrical_angle_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;

  foc_phase_voltage_modulator #(
    .ANGLE_BITS     (ANGLE_W),
    .SINE_TABLE_BITS(TABLE_W)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .shaft_angle_i,
    .uq_i,
    .ud_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .out_strobe_o,
    .phase_a_o,
    .phase_b_o,
    .phase_c_o,
    .electrical_angle_o
  );

  foc_pvm_checker #(
    .ANGLE_W(ANGLE_W),
    .TABLE_W(TABLE_W)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i            (busy_o),
    .shaft_angle_i,
    .uq_i,
    .ud_i,
    .cfg_valid_i,
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .out_strobe_i      (out_strobe_o),
    .phase_a_i         (phase_a_o),
    .phase_b_i         (phase_b_o),
    .phase_c_i         (phase_c_o),
    .electrical_angle_i(electrical_angle_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("foc_phase_voltage_modulator verification failed");
      $finish;
    end
  end

  // Send one request, opening a gap first when the current burst is used up and gap_max is nonzero.
  task automatic send_request(input logic [15:0] shaft, input logic signed [15:0] uq,
                              input logic signed [15:0] ud);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    start_i       <= 1'b1;
    shaft_angle_i <= shaft;
    uq_i          <= uq;
    ud_i          <= ud;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    requests_sent++;
  endtask

  // Stop sending and let every outstanding result drain out.
  task automatic wait_idle();
    start_i    <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (foc_pvm_pkg::TOTAL_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [foc_pvm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [foc_pvm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // New setting of all three registers, written while the block is idle.
  task automatic apply_setting(input logic [15:0] pole_data, input logic [15:0] dir_data,
                               input logic [15:0] offset_data);
    wait_idle();
    write_reg(foc_pvm_pkg::REG_POLE_COUNT, pole_data);
    write_reg(foc_pvm_pkg::REG_DIRECTION, dir_data);
    write_reg(foc_pvm_pkg::REG_ELEC_OFFSET, offset_data);
    settings_used++;
  endtask

  function automatic logic signed [15:0] pick_voltage();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_shaft();
    case ($urandom_range(0, 7))
      0:       return {2'($urandom), 14'h0000};
      1:       return {2'($urandom), 14'h3FFF};
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pole_data();
    logic [6:0] count;
    case ($urandom_range(0, 6))
      0:       count = 7'd0;
      1:       count = 7'd1;
      2:       count = 7'd64;
      3:       count = 7'd127;
      4:       count = 7'($urandom_range(65, 127));
      default: count = 7'($urandom_range(1, 64));
    endcase
    // Upper data bits are junk that the register must drop.
    return {9'($urandom), count};
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting, back to back: axis extremes and quadrant boundaries.
    gap_max = 0;
    send_request(16'h0000, 16'sh0000, 16'sh0000);
    send_request(16'h0000, 16'sh7FFF, 16'sh0000);
    send_request(16'h0000, 16'sh8000, 16'sh0000);
    send_request(16'h0000, 16'sh0000, 16'sh7FFF);
    send_request(16'h0000, 16'sh0000, 16'sh8000);
    send_request(16'h4000, 16'sh7FFF, 16'sh7FFF);
    send_request(16'h8000, 16'sh8000, 16'sh8000);
    send_request(16'hC000, 16'sh8000, 16'sh7FFF);
    send_request(16'hFFFF, 16'sh7FFF, 16'sh8000);
    send_request(16'h2000, 16'sh8000, 16'sh8000);
    send_request(16'h6000, 16'sh7FFF, 16'sh8000);
    send_request(16'h3FFF, 16'sh1234, 16'shEDCC);
    send_request(16'h3FC0, 16'sh8000, 16'sh7FFF);

    // Zero pole pairs: the angle is just the offset.
    apply_setting(16'h0000, 16'h0001, 16'h1234);
    send_request(16'hFFFF, 16'sh7FFF, 16'sh7FFF);
    send_request(16'h5A5A, 16'sh8000, 16'sh4000);
    // Largest in-range count, reverse direction with junk bits, full offset.
    apply_setting(16'h0040, 16'hFFFE, 16'hFFFF);
    send_request(16'h0001, 16'sh7FFF, 16'sh8000);
    send_request(16'hFFFF, 16'sh8000, 16'sh8000);
    send_request(16'h0400, 16'sh4000, 16'shC000);
    // Count beyond the motor range wraps; write to an unused index is dropped.
    apply_setting(16'hFFFF, 16'h0001, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(16'hFFFF, 16'sh7FFF, 16'sh0000);
    send_request(16'h1357, 16'sh0000, 16'sh8000);
    send_request(16'h8001, 16'sh2222, 16'shDDDD);

    // Random settings and traffic; every third phase runs without gaps.
    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(pick_pole_data(), {15'($urandom), 1'($urandom)}, pick_offset());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, 16'($urandom));
      end
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
      count   = $urandom_range(40, 60);
      for (int i = 0; i < int'(count); i++) begin
        send_request(pick_shaft(), pick_voltage(), pick_voltage());
      end
    end

    wait_idle();
    repeat (foc_pvm_pkg::TOTAL_LAT * 2) @(posedge clk_i);
    $display("Run covered %0d requests over %0d register settings,", requests_sent,
             settings_used + 1);
    $display("including pole counts 0 to 127, both directions and full-range offsets.");
    if (fail_count == 0) begin
      $display("foc_phase_voltage_modulator verification clean");
    end else begin
      $display("foc_phase_voltage_modulator verification failed");
    end
    $finish;
  end

endmodule
